/* rtl/assert_macros.svh */
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/clint_pkg.sv */
package clint_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  localparam logic [63:0] OFS_SOFT    = 64'h0000_0000_0000_0000;
  localparam logic [63:0] OFS_COMPARE = 64'h0000_0000_0000_4000;
  localparam logic [63:0] OFS_TIME    = 64'h0000_0000_0000_BFF8;

  localparam logic [3:0] BYTES_WORD  = 4'd4;
  localparam logic [3:0] BYTES_DWORD = 4'd8;

  localparam logic [63:0] COMPARE_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

  // decoded form of one transaction
  typedef struct packed {
    logic rd;        // successful read
    logic wr;        // successful write
    logic tick;
    logic err;
    logic hit_soft;
    logic hit_cmp;
    logic hit_time;
  } dec_t;

endpackage

/* rtl/clint_intf.sv */
interface clint_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] address;
  logic [3:0]  access_bytes;
  logic [63:0] write_data;

  modport source (output valid, opcode, address, access_bytes, write_data, input ready);
  modport sink   (input valid, opcode, address, access_bytes, write_data, output ready);
endinterface

interface clint_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        access_error;
  logic        software_irq;
  logic        timer_irq;
  logic        irq_any;

  modport source (output valid, read_data, access_error, software_irq, timer_irq, irq_any,
                  input ready);
  modport sink   (input valid, read_data, access_error, software_irq, timer_irq, irq_any,
                  output ready);
endinterface

/* rtl/core_local_timer_interruptor_unit.sv */
// Path: an accepted transaction is held in the input register and moves on into the
// result register, which drives the output handshake until the result is taken.
// Throughput: one transaction per cycle; the input register refills while a
// result waits, so the input stalls only when both stages are full and blocked.
// Reset (rst_n low, synchronous): time counter 0, compare all ones, soft bit 0,
// base address 0, both stages empty.
`include "assert_macros.svh"

module core_local_timer_interruptor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  clint_in_if.sink    in_ch,
  clint_out_if.source out_ch
);
  import clint_pkg::*;

  logic [63:0] base_r;

  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [63:0] s1_addr_r;
  logic [3:0]  s1_bytes_r;
  logic [63:0] s1_wdata_r;

  logic        out_valid_r;
  logic [63:0] rdata_r;
  logic        err_r;
  logic        sw_r;
  logic        tm_r;

  logic        s1_adv;
  logic        in_acc;
  dec_t        dec;
  logic [63:0] rdata;
  logic        soft_irq;
  logic        timer_irq;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) s1_valid_r <= 1'b1;
      else if (s1_adv) s1_valid_r <= 1'b0;
      if (s1_adv) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_ch.opcode;
      s1_addr_r  <= in_ch.address;
      s1_bytes_r <= in_ch.access_bytes;
      s1_wdata_r <= in_ch.write_data;
    end
    if (s1_adv) begin
      rdata_r <= rdata;
      err_r   <= dec.err;
      sw_r    <= soft_irq;
      tm_r    <= timer_irq;
    end
  end

  clint_decode u_decode (
    .opcode       (s1_op_r),
    .address      (s1_addr_r),
    .access_bytes (s1_bytes_r),
    .base         (base_r),
    .dec          (dec)
  );

  clint_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_adv),
    .dec       (dec),
    .wdata     (s1_wdata_r),
    .rdata     (rdata),
    .soft_irq  (soft_irq),
    .timer_irq (timer_irq)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = rdata_r;
  assign out_ch.access_error = err_r;
  assign out_ch.software_irq = sw_r;
  assign out_ch.timer_irq    = tm_r;
  assign out_ch.irq_any      = sw_r | tm_r;

  `ASSERT_NEVER(a_err_rdata_zero, clk, rst_n, out_valid_r && err_r && |rdata_r, "error with data")
  `ASSERT_AT(a_stall_full, clk, rst_n, !in_ch.ready |-> (s1_valid_r && out_valid_r), "false stall")
  `ASSERT_AT(a_s1_hold, clk, rst_n, (s1_valid_r && !s1_adv) |=> s1_valid_r, "transaction lost")
  `ASSERT_NEVER(a_dec_rdwr, clk, rst_n, s1_valid_r && dec.rd && dec.wr, "read and write")
  `ASSERT_NEVER(a_dec_errtk, clk, rst_n, s1_valid_r && dec.err && dec.tick, "error on tick")
endmodule

/* rtl/clint_decode.sv */
module clint_decode (
  input  logic [1:0]      opcode,
  input  logic [63:0]     address,
  input  logic [3:0]      access_bytes,
  input  logic [63:0]     base,
  output clint_pkg::dec_t dec
);
  import clint_pkg::*;

  logic [63:0] offset;
  logic        is_acc;
  logic        is_wr;
  logic        is_tick;
  logic        size_ok;

  assign offset = address - base;

  always_comb begin
    is_acc  = 1'b0;
    is_wr   = 1'b0;
    is_tick = 1'b0;
    unique case (opcode_t'(opcode))
      OP_READ:  is_acc = 1'b1;
      OP_WRITE: begin
        is_acc = 1'b1;
        is_wr  = 1'b1;
      end
      OP_TICK:  is_tick = 1'b1;
      default:  ;
    endcase
  end

  assign dec.tick = is_tick;

  assign dec.hit_soft = (offset == OFS_SOFT);
  assign dec.hit_cmp  = (offset == OFS_COMPARE);
  assign dec.hit_time = (offset == OFS_TIME);

  assign size_ok = (dec.hit_soft && access_bytes == BYTES_WORD) ||
                   ((dec.hit_cmp || dec.hit_time) && access_bytes == BYTES_DWORD);

  assign dec.err = is_acc && !size_ok;
  assign dec.rd  = is_acc && size_ok && !is_wr;
  assign dec.wr  = is_acc && size_ok && is_wr;
endmodule

/* rtl/clint_regs.sv */
module clint_regs (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            upd,
  input  clint_pkg::dec_t dec,
  input  logic [63:0]     wdata,
  output logic [63:0]     rdata,
  output logic            soft_irq,
  output logic            timer_irq
);
  import clint_pkg::*;

  logic        soft_r,  soft_nxt;
  logic [63:0] time_r,  time_nxt;
  logic [63:0] cmp_r,   cmp_nxt;

  always_comb begin
    soft_nxt = soft_r;
    time_nxt = time_r;
    cmp_nxt  = cmp_r;
    if (dec.tick) begin
      time_nxt = time_r + 64'd1;
    end else if (dec.wr) begin
      if (dec.hit_soft) soft_nxt = wdata[0];
      if (dec.hit_cmp)  cmp_nxt  = wdata;
      if (dec.hit_time) time_nxt = wdata;
    end
  end

  always_comb begin
    rdata = '0;
    if (dec.rd) begin
      if (dec.hit_soft)      rdata = {63'd0, soft_r};
      else if (dec.hit_cmp)  rdata = cmp_r;
      else if (dec.hit_time) rdata = time_r;
    end
  end

  // levels after this transaction
  assign soft_irq  = soft_nxt;
  assign timer_irq = (time_nxt >= cmp_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r <= 1'b0;
      time_r <= '0;
      cmp_r  <= COMPARE_RESET;
    end else if (upd) begin
      soft_r <= soft_nxt;
      time_r <= time_nxt;
      cmp_r  <= cmp_nxt;
    end
  end
endmodule
